>>> rtl/bcmc_pkg.sv
// ----------------------------------------------------------------------------
// bcmc_pkg: shared definitions of the battery charge mode controller
// Field widths, event and phase codes, register indexes and bundle types.
// ----------------------------------------------------------------------------
package bcmc_pkg;

  localparam int MODE_W    = 3;
  localparam int VOLT_W    = 14;
  localparam int MS_W      = 16;
  localparam int CURR_W    = 8;
  localparam int PHASE_W   = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 21;
  localparam int DUR_W     = 21;

  localparam int TIMER_WIDTH_DEF = 22;

  // event kinds
  localparam logic [MODE_W-1:0] MODE_MEASURE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ON      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OFF     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FULL    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OVERV   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd5;

  // charge phases
  localparam logic [PHASE_W-1:0] PH_OFF    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_READY  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PRE    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_FAST   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_NORMAL = 3'd4;
  localparam logic [PHASE_W-1:0] PH_CV     = 3'd5;
  localparam logic [PHASE_W-1:0] PH_BAL    = 3'd6;
  localparam logic [PHASE_W-1:0] PH_MAINT  = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRE_CURR  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_CURR = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_CURR = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAL_CURR  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_LIM   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_LIM  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_LIM  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BAL_DUR   = 4'd7;

  typedef struct packed {
    logic [4:0]        precharge_current;
    logic [6:0]        normal_current;
    logic [7:0]        fast_current;
    logic [4:0]        balance_current;
    logic [VOLT_W-1:0] precharge_limit;
    logic [VOLT_W-1:0] fast_limit;
    logic [VOLT_W-1:0] voltage_limit;
    logic [DUR_W-1:0]  balance_duration;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [VOLT_W-1:0] voltage;
    logic [MS_W-1:0]   elapsed_ms;
  } item_t;

  typedef struct packed {
    logic [CURR_W-1:0]  drive_current;
    logic [PHASE_W-1:0] phase;
  } res_t;

endpackage

>>> rtl/bcmc_in_if.sv
// ----------------------------------------------------------------------------
// bcmc_in_if: event channel of the charge mode controller
// Valid/ready channel carrying one event word.
// ----------------------------------------------------------------------------
interface bcmc_in_if;
  logic                        valid;
  logic                        ready;
  logic [bcmc_pkg::MODE_W-1:0] mode;
  logic [bcmc_pkg::VOLT_W-1:0] voltage;
  logic [bcmc_pkg::MS_W-1:0]   elapsed_ms;

  modport source (output valid, output mode, output voltage, output elapsed_ms,
                  input ready);
  modport sink   (input valid, input mode, input voltage, input elapsed_ms,
                  output ready);
endinterface

>>> rtl/bcmc_out_if.sv
// ----------------------------------------------------------------------------
// bcmc_out_if: result channel of the charge mode controller
// Valid/ready channel carrying drive current and phase.
// ----------------------------------------------------------------------------
interface bcmc_out_if;
  logic                         valid;
  logic                         ready;
  logic [bcmc_pkg::CURR_W-1:0]  drive_current;
  logic [bcmc_pkg::PHASE_W-1:0] phase;

  modport source (output valid, output drive_current, output phase, input ready);
  modport sink   (input valid, input drive_current, input phase, output ready);
endinterface

>>> rtl/bcmc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bcmc_cfg_regs: configuration register file
// Eight write-only registers with their reset values; unknown indexes drop.
// ----------------------------------------------------------------------------
module bcmc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bcmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcmc_pkg::CFG_DATA_W-1:0] cfg_data,
  output bcmc_pkg::cfg_t                  cfg
);

  bcmc_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bcmc_pkg::REG_PRE_CURR:  cfg_nxt.precharge_current = cfg_data[4:0];
        bcmc_pkg::REG_NORM_CURR: cfg_nxt.normal_current    = cfg_data[6:0];
        bcmc_pkg::REG_FAST_CURR: cfg_nxt.fast_current      = cfg_data[7:0];
        bcmc_pkg::REG_BAL_CURR:  cfg_nxt.balance_current   = cfg_data[4:0];
        bcmc_pkg::REG_PRE_LIM:   cfg_nxt.precharge_limit   = cfg_data[13:0];
        bcmc_pkg::REG_FAST_LIM:  cfg_nxt.fast_limit        = cfg_data[13:0];
        bcmc_pkg::REG_VOLT_LIM:  cfg_nxt.voltage_limit     = cfg_data[13:0];
        bcmc_pkg::REG_BAL_DUR:   cfg_nxt.balance_duration  = cfg_data[20:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.precharge_current <= 5'd7;
      cfg_r.normal_current    <= 7'd50;
      cfg_r.fast_current      <= 8'd100;
      cfg_r.balance_current   <= 5'd20;
      cfg_r.precharge_limit   <= 14'd3360;
      cfg_r.fast_limit        <= 14'd4100;
      cfg_r.voltage_limit     <= 14'd4350;
      cfg_r.balance_duration  <= 21'd1800000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/bcmc_core.sv
// ----------------------------------------------------------------------------
// bcmc_core: charge phase, drive current and balancing timer
// Applies one event word per advance and presents the post-event result.
// ----------------------------------------------------------------------------
module bcmc_core #(
  parameter int TIMER_WIDTH = bcmc_pkg::TIMER_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           advance,
  input  bcmc_pkg::item_t item,
  input  bcmc_pkg::cfg_t  cfg,
  output bcmc_pkg::res_t  res
);

  localparam int TW = TIMER_WIDTH;
  localparam logic [32:0] TMAX_EXT = 33'((64'd1 << (TW - 1)) - 64'd1);
  localparam logic [TW-1:0] TMAX = {1'b0, {(TW - 1){1'b1}}};
  localparam logic [TW-1:0] TMIN = {1'b1, {(TW - 1){1'b0}}};
  localparam logic signed [TW+1:0] TMIN_EXT = {3'b111, {(TW - 1){1'b0}}};

  logic [bcmc_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [bcmc_pkg::CURR_W-1:0]  curr_r, curr_nxt;
  logic [TW-1:0]                timer_r, timer_nxt;

  logic [bcmc_pkg::CURR_W-1:0]  curr_dec;
  logic signed [TW+1:0]         diff;
  logic [TW-1:0]                timer_load;

  assign curr_dec = (curr_r != '0) ? curr_r - 8'd1 : curr_r;
  assign diff = $signed({{2{timer_r[TW-1]}}, timer_r}) -
                $signed((TW + 2)'(item.elapsed_ms));
  assign timer_load = (33'(cfg.balance_duration) > TMAX_EXT) ? TMAX :
                      TW'(cfg.balance_duration);

  always_comb begin
    phase_nxt = phase_r;
    curr_nxt  = curr_r;
    timer_nxt = timer_r;
    unique case (item.mode)
      bcmc_pkg::MODE_MEASURE: begin
        unique case (phase_r)
          bcmc_pkg::PH_READY: begin
            curr_nxt = '0;
            if (item.voltage < cfg.precharge_limit)     phase_nxt = bcmc_pkg::PH_PRE;
            else if (item.voltage < cfg.fast_limit)     phase_nxt = bcmc_pkg::PH_FAST;
            else if (item.voltage < cfg.voltage_limit)  phase_nxt = bcmc_pkg::PH_NORMAL;
            else                                        phase_nxt = bcmc_pkg::PH_CV;
          end
          bcmc_pkg::PH_PRE: begin
            curr_nxt = 8'(cfg.precharge_current);
            if (item.voltage > cfg.precharge_limit) phase_nxt = bcmc_pkg::PH_FAST;
          end
          bcmc_pkg::PH_FAST: begin
            curr_nxt = cfg.fast_current;
            if (item.voltage > cfg.fast_limit) phase_nxt = bcmc_pkg::PH_NORMAL;
          end
          bcmc_pkg::PH_NORMAL: begin
            curr_nxt = 8'(cfg.normal_current);
            if (item.voltage > cfg.voltage_limit) phase_nxt = bcmc_pkg::PH_CV;
          end
          bcmc_pkg::PH_CV: begin
            if (item.voltage > cfg.voltage_limit) curr_nxt = curr_dec;
          end
          bcmc_pkg::PH_BAL: begin
            curr_nxt = 8'(cfg.balance_current);
            if (timer_r[TW-1]) phase_nxt = bcmc_pkg::PH_MAINT;
          end
          default: curr_nxt = '0;
        endcase
      end
      bcmc_pkg::MODE_ON:  phase_nxt = bcmc_pkg::PH_READY;
      bcmc_pkg::MODE_OFF: phase_nxt = bcmc_pkg::PH_OFF;
      bcmc_pkg::MODE_FULL: begin
        phase_nxt = bcmc_pkg::PH_BAL;
        timer_nxt = timer_load;
      end
      bcmc_pkg::MODE_OVERV: begin
        if (curr_r != '0) begin
          curr_nxt  = curr_dec;
          phase_nxt = bcmc_pkg::PH_CV;
        end
      end
      bcmc_pkg::MODE_TICK: begin
        if (phase_r == bcmc_pkg::PH_BAL) begin
          // floor at the most negative count
          timer_nxt = (diff < TMIN_EXT) ? TMIN : diff[TW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bcmc_pkg::PH_OFF;
      curr_r  <= '0;
      timer_r <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      curr_r  <= curr_nxt;
      timer_r <= timer_nxt;
    end
  end

  assign res.drive_current = curr_nxt;
  assign res.phase         = phase_nxt;

endmodule

>>> rtl/battery_charge_mode_controller_unit.sv
// ----------------------------------------------------------------------------
// battery_charge_mode_controller_unit: CC/CV battery charge mode controller
// Event register, single-pass phase/current/timer update, result register.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake        | payload
//   ---------+-----------+------------------+-------------------------------
//   in_ch    | in        | valid / ready    | mode, voltage, elapsed_ms
//   out_ch   | out       | valid / ready    | drive_current, phase
//   cfg_*    | in        | cfg_we only      | cfg_index, cfg_data
//
// A word accepted into the event register is applied when the result
//   slot is free, loading its result; one word per cycle unless out_ch stalls.
// Reset (rst_n low, synchronous) empties both stages, clears phase, current
//   and timer, and loads the register defaults.
// A stalled result holds in the result register while one more word waits in
//   the event register; in_ch.ready drops only when both are full.
// ----------------------------------------------------------------------------
module battery_charge_mode_controller_unit #(
  parameter int TIMER_WIDTH = bcmc_pkg::TIMER_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bcmc_in_if.sink                         in_ch,
  bcmc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [bcmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcmc_pkg::CFG_DATA_W-1:0] cfg_data
);

  bcmc_pkg::cfg_t  cfg;
  bcmc_pkg::item_t s1_item_r;
  bcmc_pkg::res_t  res, out_res_r;
  logic            s1_valid_r, s1_valid_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free, advance, in_acc;

  // the result slot is free when empty or being taken this cycle
  assign out_free = !out_valid_r || out_ch.ready;
  assign advance  = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_acc   = in_ch.valid && in_ch.ready;

  bcmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bcmc_core #(.TIMER_WIDTH(TIMER_WIDTH)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (s1_item_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc)       s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (advance)           out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // capture the event word on accept, the result on advance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.mode       <= in_ch.mode;
      s1_item_r.voltage    <= in_ch.voltage;
      s1_item_r.elapsed_ms <= in_ch.elapsed_ms;
    end
    if (advance) out_res_r <= res;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.drive_current = out_res_r.drive_current;
  assign out_ch.phase         = out_res_r.phase;

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  a_hold_event: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r)
    else $error("event word dropped while result stalled");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced word produced no result");

  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && s1_valid_r |-> advance)
    else $error("word accepted into a full event register");
`endif

endmodule
